>>> rtl/core/isort_pkg.sv
// Package for the insertion sort sequence block: state encoding and cell control.
// Used by isort_cell, insertion_sort_sequence and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    // Control that is broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg for the control struct and data width.
`timescale 1ns / 1ps
`default_nettype none

module isort_cell (
    input  wire logic                                 aclk,
    input  wire isort_pkg::cell_ctrl_t                ctrl,
    input  wire logic signed [isort_pkg::DATA_W-1:0]  key,
    input  wire logic                                 self_valid,
    input  wire logic                                 left_valid,
    input  wire logic                                 left_gt,
    input  wire logic signed [isort_pkg::DATA_W-1:0]  left_value,
    input  wire logic signed [isort_pkg::DATA_W-1:0]  right_value,
    output logic signed [isort_pkg::DATA_W-1:0]       value,
    output logic                                      gt
);

    logic signed [isort_pkg::DATA_W-1:0] value_reg;
    logic signed [isort_pkg::DATA_W-1:0] value_next;

    // Strictly greater keeps equal values in arrival order.
    assign gt    = self_valid && (value_reg > key);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.drain) begin
            value_next = right_value;
        end else if (ctrl.insert && (gt || (!self_valid && left_valid))) begin
            // Either the key lands here or the larger left neighbour moves up.
            value_next = left_gt ? left_value : key;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/insertion_sort_sequence.sv
// The first result is offered in the cycle after the transfer of the last item.
// One item per cycle is taken while a set is being filled; a set of N held values
// is then emitted at one result per cycle while m_ready is high.
// Inputs are refused while a run is being emitted. Reset clears the count, the overflow
// flag and the state machine; cell contents are not reset and count as empty.
// Depends on isort_pkg and isort_cell.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sort_sequence #(
    parameter int unsigned MAX_ITEMS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [isort_pkg::DATA_W-1:0]  s_value,
    input  wire logic                                 s_last_item,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [isort_pkg::DATA_W-1:0]       m_sorted_value,
    output logic                                      m_end_of_run,
    output logic                                      m_overflowed
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    // The store is a row of cells, cell 0 holding the smallest value. Only the
    // first count_reg cells are meaningful; the rest are treated as free.
    isort_pkg::state_t     state_reg;
    isort_pkg::state_t     state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  dropped_reg;
    logic                  dropped_next;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  full;
    isort_pkg::cell_ctrl_t ctrl;

    logic signed [isort_pkg::DATA_W-1:0] cell_value [MAX_ITEMS];
    logic                                cell_gt    [MAX_ITEMS];
    logic                                cell_valid [MAX_ITEMS];

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign full     = (count_reg == CNT_W'(MAX_ITEMS));

    // Every cell compares a new value with its own contents at once and either
    // keeps, shifts up or takes the key. Each result transfer shifts the whole
    // chain down towards cell 0.
    assign ctrl.insert = in_xfer && !full;
    assign ctrl.drain  = out_xfer;

    generate
        for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
            logic                                lv;
            logic                                lg;
            logic signed [isort_pkg::DATA_W-1:0] lval;
            logic signed [isort_pkg::DATA_W-1:0] rval;

            assign cell_valid[i] = (CNT_W'(i) < count_reg);

            if (i == 0) begin : g_head
                assign lv   = 1'b1;
                assign lg   = 1'b0;
                assign lval = s_value;
            end else begin : g_body
                assign lv   = cell_valid[i-1];
                assign lg   = cell_gt[i-1];
                assign lval = cell_value[i-1];
            end

            if (i == MAX_ITEMS - 1) begin : g_tail
                assign rval = cell_value[i];
            end else begin : g_mid
                assign rval = cell_value[i+1];
            end

            isort_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .key         (s_value),
                .self_valid  (cell_valid[i]),
                .left_valid  (lv),
                .left_gt     (lg),
                .left_value  (lval),
                .right_value (rval),
                .value       (cell_value[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            isort_pkg::ST_FILL: begin
                if (in_xfer && s_last_item) begin
                    state_next = isort_pkg::ST_DRAIN;
                end
            end
            isort_pkg::ST_DRAIN: begin
                if (out_xfer && m_end_of_run) begin
                    state_next = isort_pkg::ST_FILL;
                end
            end
            default: begin
                state_next = isort_pkg::ST_FILL;
            end
        endcase
    end

    // Handshake outputs. The result is taken straight from cell 0, which is a
    // register, together with the remaining count and the sticky flag.
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            isort_pkg::ST_FILL: begin
                s_ready = 1'b1;
            end
            isort_pkg::ST_DRAIN: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_sorted_value = cell_value[0];
    assign m_end_of_run   = (count_reg == CNT_W'(1));
    assign m_overflowed   = dropped_reg;

    // The count grows on each insertion, and during a run it counts the
    // results still to be sent, so it reaches zero as the run finishes. An
    // item that meets a full store is dropped and sets the sticky flag.
    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (in_xfer) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (out_xfer) begin
            count_next = count_reg - CNT_W'(1);
            if (m_end_of_run) begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= isort_pkg::ST_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("held count beyond store depth");

    // A run always offers at least one result.
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (count_reg != '0))
        else $error("result offered from an empty store");

    // The last transfer of a run leaves the store empty and the flag clear.
    a_run_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && m_end_of_run) |=> (count_reg == '0 && !dropped_reg && s_ready))
        else $error("store not emptied after run");

    // The two smallest held values are in ascending order while emitting.
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && count_reg >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
        else $error("chain out of order");

    // Inputs are never taken while a run is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted during a run");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for insertion_sort_sequence: streams sets of signed values,
// predicts each sorted run and checks every result transfer against that prediction.
// Depends on isort_pkg and the insertion_sort_sequence RTL; reads no files.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    // The store depth must match the parameter given to the instance below.
    localparam int unsigned STORE_DEPTH    = 16;
    // The longest legal stretch without a transfer is one long stall or gap from
    // pick_gap, so this limit leaves a wide margin.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned DRAIN_CYCLES   = 20;

    localparam logic signed [isort_pkg::DATA_W-1:0] INT_MIN =
        {1'b1, {(isort_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [isort_pkg::DATA_W-1:0] INT_MAX =
        {1'b0, {(isort_pkg::DATA_W-1){1'b1}}};

    // Patterns for the content of a random set.
    typedef enum int {
        PAT_RANDOM,
        PAT_ASCENDING,
        PAT_DESCENDING
    } set_pattern_t;

    // One result as it should appear on the m_ channel.
    typedef struct packed {
        logic signed [isort_pkg::DATA_W-1:0] value;
        logic                                end_of_run;
        logic                                overflowed;
    } sort_result_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [isort_pkg::DATA_W-1:0] s_value;
    logic                                s_last_item;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [isort_pkg::DATA_W-1:0] m_sorted_value;
    logic                                m_end_of_run;
    logic                                m_overflowed;

    // Predictor state: the values held for the open set, kept in ascending
    // order, and the sticky flag that records a dropped item.
    logic signed [isort_pkg::DATA_W-1:0] held_values[$];
    logic                                set_dropped;
    // Results still owed by the block, oldest first.
    sort_result_t                        sorted_expect[$];

    // Idling controls, set by each test: the chance in percent that a gap starts
    // before a given item or that a stall starts at a given cycle.
    int unsigned source_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned stall_left;

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned sets_sent;
    int unsigned overflow_sets;
    int unsigned results_checked;
    int unsigned idle_cycles;

    insertion_sort_sequence #(
        .MAX_ITEMS(STORE_DEPTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_end_of_run  (m_end_of_run),
        .m_overflowed  (m_overflowed)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    // Most gaps and stalls are short; roughly one in ten is long.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Values are biased towards the extremes and towards a narrow band around
    // zero, so that duplicates and sign boundaries turn up often.
    function automatic logic signed [isort_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                return INT_MIN;
            end
            1: begin
                return INT_MAX;
            end
            2, 3: begin
                return $signed($urandom_range(0, 8)) - 4;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    // Inserts an accepted value into the predicted store, after any equal
    // values, or marks the set as overflowed when the store is already full.
    // A last item then releases the whole store as the expected run.
    function automatic void predict_sorted_run(logic signed [isort_pkg::DATA_W-1:0] value,
                                               logic last);
        int unsigned  pos;
        sort_result_t res;
        if (held_values.size() < STORE_DEPTH) begin
            pos = held_values.size();
            while (pos > 0 && held_values[pos-1] > value) begin
                pos--;
            end
            held_values.insert(pos, value);
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            foreach (held_values[i]) begin
                res.value      = held_values[i];
                res.end_of_run = (i == held_values.size() - 1);
                res.overflowed = set_dropped;
                sorted_expect.push_back(res);
            end
            sets_sent++;
            if (set_dropped) begin
                overflow_sets++;
            end
            held_values.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // Offers one item and returns at the falling edge after its transfer.
    // Valid is only lowered when a gap is taken, so back-to-back items keep it
    // high without a second assignment in the same time step.
    task automatic send_item(logic signed [isort_pkg::DATA_W-1:0] value, logic last);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(1, 100) <= source_gap_pct) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_value     <= value;
        s_last_item <= last;
        s_valid     <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_sorted_run(value, last);
        items_sent++;
        @(negedge aclk);
    endtask

    // Sends whole sets until at least item_budget items have been transferred.
    // Most sets fit the store; some fill it exactly and some run past it.
    task automatic send_random_sets(int unsigned item_budget);
        int unsigned                         target;
        int unsigned                         set_len;
        set_pattern_t                        pattern;
        logic signed [isort_pkg::DATA_W-1:0] seed_value;
        logic signed [isort_pkg::DATA_W-1:0] value;
        target = items_sent + item_budget;
        while (items_sent < target) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    set_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
                end
                3, 4, 5: begin
                    set_len = STORE_DEPTH;
                end
                default: begin
                    set_len = $urandom_range(1, 8);
                end
            endcase
            pattern    = set_pattern_t'($urandom_range(PAT_RANDOM, PAT_DESCENDING));
            seed_value = pick_value();
            for (int unsigned i = 0; i < set_len; i++) begin
                case (pattern)
                    PAT_ASCENDING: begin
                        value = seed_value + i;
                    end
                    PAT_DESCENDING: begin
                        value = seed_value - i;
                    end
                    default: begin
                        value = pick_value();
                    end
                endcase
                send_item(value, i == set_len - 1);
            end
        end
    endtask

    // Directed sets: a single minimum value, a set that spans both extremes
    // with a duplicate, and a set that fills the store so that the closing
    // item itself is dropped.
    task automatic test_directed_cases();
        source_gap_pct = 0;
        sink_stall_pct = 0;
        send_item(INT_MIN, 1'b1);
        send_item(INT_MAX, 1'b0);
        send_item(INT_MIN, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(5, 1'b0);
        send_item(1, 1'b0);
        send_item(5, 1'b1);
        for (int unsigned i = 0; i < STORE_DEPTH; i++) begin
            send_item(INT_MAX - i, 1'b0);
        end
        send_item(INT_MIN, 1'b1);
    endtask

    // Items and results move at full rate, with no idling on either side.
    task automatic test_back_to_back();
        source_gap_pct = 0;
        sink_stall_pct = 0;
        send_random_sets(80);
    endtask

    // Gaps and stalls of random length fall on every phase of fill and drain.
    task automatic test_random_idling();
        source_gap_pct = 30;
        sink_stall_pct = 30;
        send_random_sets(85);
    endtask

    // The result side stalls most of the time while items arrive quickly.
    task automatic test_heavy_backpressure();
        source_gap_pct = 10;
        sink_stall_pct = 70;
        send_random_sets(80);
    endtask

    // Result-side ready, changed at the falling edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(1, 100) <= sink_stall_pct) begin
            m_ready    <= 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result transfer is compared with the oldest expected result.
    always @(posedge aclk) begin : result_check
        sort_result_t got;
        sort_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.value      = m_sorted_value;
            got.end_of_run = m_end_of_run;
            got.overflowed = m_overflowed;
            results_checked++;
            if (sorted_expect.size() == 0) begin
                note_failure($sformatf("unexpected result value=%0d end=%0b ovf=%0b",
                    got.value, got.end_of_run, got.overflowed));
            end else begin
                want = sorted_expect.pop_front();
                if (got.value !== want.value || got.end_of_run !== want.end_of_run
                        || got.overflowed !== want.overflowed) begin
                    note_failure($sformatf(
                        "expected value=%0d end=%0b ovf=%0b, got value=%0d end=%0b ovf=%0b",
                        want.value, want.end_of_run, want.overflowed,
                        got.value, got.end_of_run, got.overflowed));
                end
            end
        end
    end

    // A run that stops moving on both channels is a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_value         = '0;
        s_last_item     = 1'b0;
        m_ready         = 1'b0;
        set_dropped     = 1'b0;
        source_gap_pct  = 0;
        sink_stall_pct  = 0;
        stall_left      = 0;
        mismatch_count  = 0;
        items_sent      = 0;
        sets_sent       = 0;
        overflow_sets   = 0;
        results_checked = 0;
        idle_cycles     = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_back_to_back();
        test_random_idling();
        test_heavy_backpressure();
        s_valid <= 1'b0;

        // Let the last run drain; the watchdog ends the run should it stall.
        while (sorted_expect.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sorted_expect.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", sorted_expect.size()));
        end

        $display("Sent %0d items in %0d sets, %0d of them past the store depth.",
            items_sent, sets_sent, overflow_sets);
        $display("Checked %0d sorted results; %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> insertion_sort_sequence.f
rtl/core/isort_pkg.sv
rtl/core/isort_cell.sv
rtl/core/insertion_sort_sequence.sv
test/testbench.sv
